@@ rtl/apsp_pkg.sv @@
// Shared types and constants of the all-pairs shortest path block.
`default_nettype none

package apsp_pkg;

  // Fixed field widths of the ports
  localparam int unsigned COORD_W     = 6;
  localparam int unsigned NEXT_W      = 6;
  localparam int unsigned IN_WEIGHT_W = 32;
  localparam int unsigned OUT_DIST_W  = 32;
  localparam int unsigned VCOUNT_W    = 7;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  // Index fields in the controller command are sized for the largest vertex count
  localparam int unsigned IDX_W = 10;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_SET_EDGE = 2'd1,
    CMD_RUN      = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_SET,
    OP_LOAD,
    OP_RELAX,
    OP_READ,
    OP_OUT_DATA,
    OP_OUT_RANGE,
    OP_OUT_DONE
  } dp_op_e;

  typedef enum logic [1:0] {
    RPL_DATA,
    RPL_RANGE,
    RPL_DONE
  } reply_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ROW,
    ST_COL,
    ST_DRAIN,
    ST_REPLY
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e           op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] kidx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/apsp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module apsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/apsp_ctrl.sv @@
// Controller: command decode, loop counters for clear and relaxation, reply sequencing.
`default_nettype none

module apsp_ctrl import apsp_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          command_i,
  input  wire logic [COORD_W-1:0]  row_i,
  input  wire logic [COORD_W-1:0]  col_i,
  input  wire logic                cfg_we_i,
  input  wire logic [VCOUNT_W-1:0] cfg_wdata_i,
  input  wire dp_stat_t            stat_i,
  output dp_cmd_t                  cmd_o
);

  localparam int unsigned IW = $clog2(MAX_VERTICES);
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
  localparam logic [IW-1:0] IDX_TOP = IW'(MAX_VERTICES - 1);

  ctrl_state_e          state_q, state_d;
  reply_e               reply_q, reply_d;
  logic [IW-1:0]        k_q, k_d, i_q, i_d, j_q, j_d;
  logic [VCOUNT_W-1:0]  vcount_q;
  logic [NW-1:0]        n_act, n_last;
  logic                 row_ok, col_ok;
  logic                 k_last, i_last, j_last;

  // Active vertex count, limited to the storage size
  assign n_act  = (32'(vcount_q) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcount_q);
  assign n_last = n_act - NW'(1);
  assign row_ok = 32'(row_i) < 32'(n_act);
  assign col_ok = 32'(col_i) < 32'(n_act);
  assign k_last = NW'(k_q) == n_last;
  assign i_last = NW'(i_q) == n_last;
  assign j_last = NW'(j_q) == n_last;

  // State, counters and vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      reply_q  <= RPL_DONE;
      k_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      vcount_q <= VCOUNT_RESET;
    end else begin
      state_q <= state_d;
      reply_q <= reply_d;
      k_q     <= k_d;
      i_q     <= i_d;
      j_q     <= j_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    reply_d    = reply_q;
    k_d        = k_q;
    i_d        = i_q;
    j_d        = j_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.op   = OP_NOP;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (cmd_e'(command_i))
            CMD_CLEAR: begin
              i_d     = '0;
              j_d     = '0;
              state_d = ST_CLEAR;
            end
            CMD_SET_EDGE: begin
              if (row_ok && col_ok) begin
                cmd_o.op  = OP_SET;
                cmd_o.row = IDX_W'(row_i);
                cmd_o.col = IDX_W'(col_i);
              end
            end
            CMD_RUN: begin
              k_d = '0;
              i_d = '0;
              j_d = '0;
              if (n_act == '0) begin
                reply_d = RPL_DONE;
                state_d = ST_REPLY;
              end else begin
                state_d = ST_ROW;
              end
            end
            CMD_READ: begin
              if (row_ok && col_ok) begin
                cmd_o.op  = OP_READ;
                cmd_o.row = IDX_W'(row_i);
                cmd_o.col = IDX_W'(col_i);
                reply_d   = RPL_DATA;
              end else begin
                reply_d   = RPL_RANGE;
              end
              state_d = ST_REPLY;
            end
            default: ;
          endcase
        end
      end

      // One matrix entry per cycle over the whole storage
      ST_CLEAR: begin
        cmd_o.op  = OP_CLEAR;
        cmd_o.row = IDX_W'(i_q);
        cmd_o.col = IDX_W'(j_q);
        if (j_q == IDX_TOP) begin
          j_d = '0;
          if (i_q == IDX_TOP) begin
            state_d = ST_IDLE;
          end else begin
            i_d = i_q + IW'(1);
          end
        end else begin
          j_d = j_q + IW'(1);
        end
      end

      // Fetch d[i][k] and next[i][k] for the coming row
      ST_ROW: begin
        cmd_o.op   = OP_LOAD;
        cmd_o.row  = IDX_W'(i_q);
        cmd_o.kidx = IDX_W'(k_q);
        j_d        = '0;
        state_d    = ST_COL;
      end

      // One relaxation per cycle along the row
      ST_COL: begin
        cmd_o.op   = OP_RELAX;
        cmd_o.row  = IDX_W'(i_q);
        cmd_o.col  = IDX_W'(j_q);
        cmd_o.kidx = IDX_W'(k_q);
        if (j_last) begin
          if (i_last) begin
            i_d = '0;
            if (k_last) begin
              state_d = ST_DRAIN;
            end else begin
              k_d     = k_q + IW'(1);
              state_d = ST_ROW;
            end
          end else begin
            i_d     = i_q + IW'(1);
            state_d = ST_ROW;
          end
        end else begin
          j_d = j_q + IW'(1);
        end
      end

      // Last write-back of the run completes here
      ST_DRAIN: begin
        reply_d = RPL_DONE;
        state_d = ST_REPLY;
      end

      ST_REPLY: begin
        if (stat_i.out_free) begin
          case (reply_q)
            RPL_DATA:  cmd_o.op = OP_OUT_DATA;
            RPL_RANGE: cmd_o.op = OP_OUT_RANGE;
            default:   cmd_o.op = OP_OUT_DONE;
          endcase
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/apsp_dp.sv @@
// Datapath: distance and next-hop storage, saturating relaxation unit, output register.
`default_nettype none

module apsp_dp import apsp_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned WEIGHT_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic signed [IN_WEIGHT_W-1:0] weight_i,
  input  wire dp_cmd_t                       cmd_i,
  output dp_stat_t                           stat_o,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic                               kind_o,
  output logic signed [OUT_DIST_W-1:0]       distance_o,
  output logic        [NEXT_W-1:0]           next_vertex_o,
  output logic                               reachable_o
);

  localparam int unsigned IW    = $clog2(MAX_VERTICES);
  localparam int unsigned AW    = 2 * IW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned WW    = WEIGHT_WIDTH;

  localparam logic signed [WW-1:0] D_INF   = {1'b0, {(WW-1){1'b1}}};
  localparam logic signed [WW-1:0] D_MIN   = {1'b1, {(WW-1){1'b0}}};
  localparam logic signed [WW:0]   INF_X   = (WW+1)'(D_INF);
  localparam logic signed [WW:0]   MIN_X   = (WW+1)'(D_MIN);
  localparam logic signed [63:0]   INF_64  = 64'(D_INF);
  localparam logic signed [63:0]   MIN_64  = 64'(D_MIN);
  localparam logic signed [63:0]   I32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0]   I32_MIN = 64'shFFFF_FFFF_8000_0000;

  logic [IW-1:0] c_row, c_col, c_k;

  logic          dist_we, dist_a_re, dist_b_re, next_re;
  logic [AW-1:0] waddr, dist_a_raddr, dist_b_raddr, next_raddr;
  logic [WW-1:0] dist_wdata, dist_a_rdata, dist_b_rdata;
  logic [NEXT_W-1:0] next_wdata, next_rdata;

  logic signed [WW-1:0] d_kj, d_ij, d_rd;
  logic signed [WW-1:0] dik_q, s_sum, w_clamp;
  logic signed [WW:0]   sum_ext;
  logic signed [63:0]   w_64, d_rd_64;
  logic [NEXT_W-1:0]    nik_q;
  logic                 better;

  logic                 relax_pend_q, load_pend_q, diag_q;
  logic [IW-1:0]        wr_row_q, wr_col_q;

  logic                 out_valid_q, out_load;
  logic                 kind_q, reach_q;
  logic [OUT_DIST_W-1:0] dist_q;
  logic [NEXT_W-1:0]    next_q;
  logic                 rd_reach;
  logic [OUT_DIST_W-1:0] rd_shown;

  assign c_row = cmd_i.row[IW-1:0];
  assign c_col = cmd_i.col[IW-1:0];
  assign c_k   = cmd_i.kidx[IW-1:0];

  // Two copies of the distance matrix give two reads per cycle
  apsp_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_dist_a (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (waddr),
    .wdata_i (dist_wdata),
    .re_i    (dist_a_re),
    .raddr_i (dist_a_raddr),
    .rdata_o (dist_a_rdata)
  );

  apsp_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_dist_b (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (waddr),
    .wdata_i (dist_wdata),
    .re_i    (dist_b_re),
    .raddr_i (dist_b_raddr),
    .rdata_o (dist_b_rdata)
  );

  apsp_ram #(.WIDTH(NEXT_W), .DEPTH(DEPTH)) u_next (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (waddr),
    .wdata_i (next_wdata),
    .re_i    (next_re),
    .raddr_i (next_raddr),
    .rdata_o (next_rdata)
  );

  // Read port steering
  assign dist_a_re    = (cmd_i.op == OP_LOAD) || (cmd_i.op == OP_RELAX) ||
                        (cmd_i.op == OP_READ);
  assign dist_b_re    = cmd_i.op == OP_RELAX;
  assign next_re      = (cmd_i.op == OP_LOAD) || (cmd_i.op == OP_READ);
  assign dist_a_raddr = (cmd_i.op == OP_RELAX) ? {c_k, c_col} :
                        (cmd_i.op == OP_LOAD)  ? {c_row, c_k} : {c_row, c_col};
  assign dist_b_raddr = {c_row, c_col};
  assign next_raddr   = (cmd_i.op == OP_LOAD) ? {c_row, c_k} : {c_row, c_col};

  // Saturating d[i][k] + d[k][j]; infinity absorbs
  assign d_kj    = dist_a_rdata;
  assign d_ij    = dist_b_rdata;
  assign sum_ext = (WW+1)'(dik_q) + (WW+1)'(d_kj);
  always_comb begin
    if (dik_q == D_INF || d_kj == D_INF) begin
      s_sum = D_INF;
    end else if (sum_ext > INF_X) begin
      s_sum = D_INF;
    end else if (sum_ext < MIN_X) begin
      s_sum = D_MIN;
    end else begin
      s_sum = sum_ext[WW-1:0];
    end
  end
  assign better = relax_pend_q && (s_sum < d_ij);

  // Set-edge weight clamped to the storage range
  assign w_64 = 64'(weight_i);
  always_comb begin
    if (w_64 > INF_64) begin
      w_clamp = D_INF;
    end else if (w_64 < MIN_64) begin
      w_clamp = D_MIN;
    end else begin
      w_clamp = WW'(w_64);
    end
  end

  // Write port: relaxation write-back, clear sweep or set edge
  always_comb begin
    dist_we    = 1'b0;
    waddr      = {c_row, c_col};
    dist_wdata = w_clamp;
    next_wdata = NEXT_W'(c_col);
    if (better) begin
      dist_we    = 1'b1;
      waddr      = {wr_row_q, wr_col_q};
      dist_wdata = s_sum;
      next_wdata = nik_q;
    end else if (cmd_i.op == OP_CLEAR) begin
      dist_we    = 1'b1;
      dist_wdata = (c_row == c_col) ? '0 : D_INF;
    end else if (cmd_i.op == OP_SET) begin
      dist_we    = 1'b1;
    end
  end

  // Relaxation pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_pend_q <= 1'b0;
      load_pend_q  <= 1'b0;
    end else begin
      relax_pend_q <= cmd_i.op == OP_RELAX;
      load_pend_q  <= cmd_i.op == OP_LOAD;
    end
  end

  // Write-back address and row operands; d[i][k] follows its own update at j == k
  always_ff @(posedge clk_i) begin
    wr_row_q <= c_row;
    wr_col_q <= c_col;
    diag_q   <= c_col == c_k;
    if (load_pend_q) begin
      dik_q <= dist_a_rdata;
      nik_q <= next_rdata;
    end else if (better && diag_q) begin
      dik_q <= s_sum;
    end
  end

  // Read result formatting to the 32-bit port
  assign d_rd     = dist_a_rdata;
  assign d_rd_64  = 64'(d_rd);
  assign rd_reach = d_rd != D_INF;
  always_comb begin
    if (!rd_reach || d_rd_64 > I32_MAX) begin
      rd_shown = OUT_DIST_W'(I32_MAX);
    end else if (d_rd_64 < I32_MIN) begin
      rd_shown = OUT_DIST_W'(I32_MIN);
    end else begin
      rd_shown = d_rd_64[OUT_DIST_W-1:0];
    end
  end

  // Output register
  assign out_load        = (cmd_i.op == OP_OUT_DATA) || (cmd_i.op == OP_OUT_RANGE) ||
                           (cmd_i.op == OP_OUT_DONE);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      case (cmd_i.op)
        OP_OUT_DATA: begin
          kind_q  <= 1'b0;
          dist_q  <= rd_shown;
          next_q  <= next_rdata;
          reach_q <= rd_reach;
        end
        OP_OUT_RANGE: begin
          kind_q  <= 1'b0;
          dist_q  <= OUT_DIST_W'(I32_MAX);
          next_q  <= '0;
          reach_q <= 1'b0;
        end
        default: begin
          kind_q  <= 1'b1;
          dist_q  <= '0;
          next_q  <= '0;
          reach_q <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign distance_o    = dist_q;
  assign next_vertex_o = next_q;
  assign reachable_o   = reach_q;

endmodule

`default_nettype wire

@@ rtl/all_pairs_shortest_path.sv @@
// All-pairs shortest path (Floyd-Warshall with next hop), top level.
// Set edge stays idle; a read result goes through the RAM and output registers.
// Clear sweeps all MAX_VERTICES*MAX_VERTICES entries, one entry per cycle.
// A run over n active vertices ends with a done reply:
// one relaxation unit does one (k,i,j) update per cycle plus one row-operand fetch per (k,i).
// Reset sets vertex_count to 64; the matrices hold no defined value until cleared.
`default_nettype none

module all_pairs_shortest_path import apsp_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned WEIGHT_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    command_i,
  input  wire logic [COORD_W-1:0]            row_i,
  input  wire logic [COORD_W-1:0]            col_i,
  input  wire logic signed [IN_WEIGHT_W-1:0] weight_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               kind_o,
  output logic signed [OUT_DIST_W-1:0]       distance_o,
  output logic        [NEXT_W-1:0]           next_vertex_o,
  output logic                               reachable_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [VCOUNT_W-1:0]           cfg_wdata_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  apsp_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  apsp_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_WIDTH (WEIGHT_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .weight_i      (weight_i),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .distance_o    (distance_o),
    .next_vertex_o (next_vertex_o),
    .reachable_o   (reachable_o)
  );

endmodule

`default_nettype wire
